// ===== design/gait_event_detector_assert.svh =====
// ----------------------------------------------------------------------------
// Gait event detector assertion macros
// Concurrent check wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GAIT_EVENT_DETECTOR_ASSERT_SVH
`define GAIT_EVENT_DETECTOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define GED_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gait event detector check failed");
// next-cycle implication
`define GED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gait event detector check failed");
`else
`define GED_ASSERT_SAME(label, clk, rst, ante, cons)
`define GED_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/ged_pkg.sv =====
// ----------------------------------------------------------------------------
// Gait event detector package
// Shared types, register indexes, reset values and detection constants.
// ----------------------------------------------------------------------------
package ged_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_PASS_THRESHOLD     = 2'd0;
   localparam logic [1:0] REG_MIDSWING_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_DOWNSTAIRS_GAP     = 2'd2;
   localparam logic [1:0] REG_OVERGROUND_LEVEL   = 2'd3;

   localparam logic signed [15:0] PASS_THRESHOLD_RESET     = 16'sd1442;
   localparam logic signed [15:0] MIDSWING_THRESHOLD_RESET = 16'sd1442;
   localparam logic [31:0]        DOWNSTAIRS_GAP_RESET     = 32'd0;
   localparam logic signed [15:0] OVERGROUND_LEVEL_RESET   = 16'sd0;

   // minimum gaps in ms, all strict
   localparam logic [31:0] ZC_GAP_MS = 32'd40;
   localparam logic [31:0] LP_GAP_MS = 32'd180;
   localparam logic [31:0] TO_GAP_MS = 32'd210;

   // 0.8 and 0.9 in 1/256 units
   localparam logic signed [25:0] LP_FRACTION = 26'sd205;
   localparam logic signed [25:0] TO_FRACTION = 26'sd230;

   localparam logic signed [15:0] UPSTAIRS_RATE = 16'sd100;
   localparam logic signed [16:0] STILL_SPREAD  = 17'sd48;
   localparam logic signed [15:0] STILL_FLOOR   = -16'sd128;

   localparam logic signed [15:0] RATE_MIN = -16'sd32768;
   localparam logic signed [15:0] RATE_MAX = 16'sd32767;

   typedef enum logic [2:0] {
      CLS_UNKNOWN    = 3'd0,
      CLS_STATIONARY = 3'd1,
      CLS_OVERGROUND = 3'd2,
      CLS_TRANSITION = 3'd3,
      CLS_DOWNSTAIRS = 3'd4,
      CLS_UPSTAIRS   = 3'd5
   } activity_type;

   typedef enum logic [1:0] {
      PAR_NONE = 2'd0,
      PAR_ODD  = 2'd1,
      PAR_EVEN = 2'd2
   } parity_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_EVAL
   } ctrl_state_type;

   typedef struct packed {
      logic load;    // capture sample, write window, restart scan
      logic read;    // read next window entry
      logic commit;  // update tracking state and load result
   } ged_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } ged_stat_type;

endpackage

// ===== design/ged_req_if.sv =====
// ----------------------------------------------------------------------------
// Gait event detector sample channel
// Valid/ready channel carrying one gyro sample and its timestamp.
// ----------------------------------------------------------------------------
interface ged_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] gyro_rate;
   logic [31:0]        time_ms;

   modport source (output valid, output gyro_rate, output time_ms, input ready);
   modport sink   (input valid, input gyro_rate, input time_ms, output ready);
endinterface

// ===== design/ged_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Gait event detector result channel
// Valid/ready channel carrying event flags and the activity class.
// ----------------------------------------------------------------------------
interface ged_rsp_if;
   logic       valid;
   logic       ready;
   logic       heel_strike;
   logic       zero_crossing;
   logic       lambda_peak;
   logic       toe_off;
   logic       midswing;
   logic [2:0] activity;

   modport source (output valid, output heel_strike, output zero_crossing,
                   output lambda_peak, output toe_off, output midswing,
                   output activity, input ready);
   modport sink   (input valid, input heel_strike, input zero_crossing,
                   input lambda_peak, input toe_off, input midswing,
                   input activity, output ready);
endinterface

// ===== design/ged_datapath.sv =====
// ----------------------------------------------------------------------------
// Gait event detector datapath
// Sample window memory, min/max scan, event tests, tracking state, result.
// ----------------------------------------------------------------------------
module ged_datapath
   import ged_pkg::*;
#(
   parameter int WINDOW_DEPTH = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  ged_cmd_type        cmd,
   output ged_stat_type       stat,
   input  logic signed [15:0] in_rate,
   input  logic [31:0]        in_time,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   ged_rsp_if.source          rsp
);

   localparam int IDX_W  = $clog2(WINDOW_DEPTH);
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

   function automatic parity_type count_crossing(input parity_type par);
      return (par == PAR_ODD) ? PAR_EVEN : PAR_ODD;
   endfunction

   // configuration
   logic signed [15:0] pass_thr_ff;
   logic signed [15:0] ms_thr_ff;
   logic [31:0]        down_gap_ff;
   logic signed [15:0] over_lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_thr_ff <= PASS_THRESHOLD_RESET;
         ms_thr_ff   <= MIDSWING_THRESHOLD_RESET;
         down_gap_ff <= DOWNSTAIRS_GAP_RESET;
         over_lvl_ff <= OVERGROUND_LEVEL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_PASS_THRESHOLD:     pass_thr_ff <= csr_data[15:0];
            REG_MIDSWING_THRESHOLD: ms_thr_ff   <= csr_data[15:0];
            REG_DOWNSTAIRS_GAP:     down_gap_ff <= csr_data;
            REG_OVERGROUND_LEVEL:   over_lvl_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // window memory and scan
   logic signed [15:0] window_mem [WINDOW_DEPTH];
   logic signed [15:0] rd_data_ff;
   logic signed [15:0] wz_ff;
   logic [31:0]        now_ff;
   logic [IDX_W-1:0]   head_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               rd_vld_ff;
   logic signed [15:0] wmax_ff;
   logic signed [15:0] wmin_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         window_mem[head_ff] <= in_rate;
      end
      if (cmd.read) begin
         rd_data_ff <= window_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         fill_ff   <= '0;
         rd_idx_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.read;
         if (cmd.load) begin
            head_ff   <= (head_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
            rd_idx_ff <= '0;
            if (fill_ff < FILL_W'(WINDOW_DEPTH)) begin
               fill_ff <= fill_ff + FILL_W'(1);
            end
         end else if (cmd.read) begin
            rd_idx_ff <= rd_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wz_ff   <= in_rate;
         now_ff  <= in_time;
         wmax_ff <= RATE_MIN;
         wmin_ff <= RATE_MAX;
      end else if (rd_vld_ff) begin
         if (rd_data_ff > wmax_ff) wmax_ff <= rd_data_ff;
         if (rd_data_ff < wmin_ff) wmin_ff <= rd_data_ff;
      end
   end

   assign stat.scan_last = (FILL_W'(rd_idx_ff) == fill_ff - FILL_W'(1));

   // tracking state
   logic signed [15:0] last_rate_ff;
   logic signed [15:0] older_rate_ff;
   parity_type         parity_ff;
   logic               lambda_armed_ff;
   logic               ms_armed_ff;
   logic               cross_armed_ff;
   logic               toe_armed_ff;
   logic signed [15:0] heel_rate_ff;
   logic [31:0]        heel_time_ff;
   logic [31:0]        ms_time_ff;
   logic [31:0]        lambda_time_ff;
   logic [31:0]        heel_gap_ff;
   activity_type       class_ff;

   // event evaluation, in the order the tests see each other's updates
   parity_type         par_a, par_b, parity_in;
   logic               is_min, is_max;
   logic               hs, zc, lp, to, ms;
   logic signed [15:0] heel_rate_in;
   logic [31:0]        heel_time_in;
   logic [31:0]        heel_gap_in;
   logic [31:0]        lambda_time_in;
   logic [31:0]        ms_time_in;
   logic               lambda_armed_in, ms_armed_in, cross_armed_in, toe_armed_in;
   logic               ms_armed_mid, cross_armed_mid, toe_armed_mid, lambda_armed_mid;
   logic [31:0]        since_heel, since_lambda;
   logic signed [25:0] pp_scaled, p_scaled, heel_lp, heel_to;
   logic signed [16:0] spread;
   activity_type       class_in;

   always_comb begin
      par_a = parity_ff;
      if (wz_ff >= pass_thr_ff && last_rate_ff <= pass_thr_ff) par_a = count_crossing(par_a);
      par_b = par_a;
      if (wz_ff <= pass_thr_ff && last_rate_ff >= pass_thr_ff) par_b = count_crossing(par_b);

      is_min = (last_rate_ff <= older_rate_ff) && (last_rate_ff <= wz_ff);
      is_max = (last_rate_ff >= older_rate_ff) && (last_rate_ff >= wz_ff);

      hs = is_min && (last_rate_ff < 16'sd0) && (par_b == PAR_EVEN);
      parity_in        = hs ? PAR_NONE : par_b;
      heel_time_in     = hs ? now_ff : heel_time_ff;
      heel_rate_in     = hs ? last_rate_ff : heel_rate_ff;
      heel_gap_in      = hs ? now_ff - ms_time_ff : heel_gap_ff;
      lambda_armed_mid = lambda_armed_ff | hs;
      ms_armed_mid     = ms_armed_ff | hs;
      cross_armed_mid  = cross_armed_ff | hs;

      since_heel = now_ff - heel_time_in;
      zc = (last_rate_ff < 16'sd0) && (wz_ff > 16'sd0) && cross_armed_mid
           && (since_heel > ZC_GAP_MS);

      pp_scaled = 26'(older_rate_ff) <<< 8;
      heel_lp   = 26'(heel_rate_in) * LP_FRACTION;
      lp = is_max && (pp_scaled > heel_lp) && (older_rate_ff < pass_thr_ff)
           && lambda_armed_mid && (since_heel > LP_GAP_MS);
      lambda_time_in  = lp ? now_ff : lambda_time_ff;
      lambda_armed_in = lambda_armed_mid & ~lp;
      toe_armed_mid   = toe_armed_ff | lp;
      cross_armed_in  = cross_armed_mid & ~zc & ~lp;

      class_in = class_ff;
      if (lp) begin
         if (wz_ff >= UPSTAIRS_RATE) class_in = CLS_UPSTAIRS;
         if (heel_gap_in > down_gap_ff) begin
            class_in = CLS_DOWNSTAIRS;
         end else if (wz_ff < 16'sd0) begin
            if (class_ff == CLS_UPSTAIRS || class_ff == CLS_DOWNSTAIRS
                || class_ff == CLS_STATIONARY) class_in = CLS_TRANSITION;
            if (heel_rate_in < over_lvl_ff) class_in = CLS_OVERGROUND;
         end
      end

      since_lambda = now_ff - lambda_time_in;
      p_scaled = 26'(last_rate_ff) <<< 8;
      heel_to  = 26'(heel_rate_in) * TO_FRACTION;
      to = is_min && (p_scaled < heel_to) && toe_armed_mid && (since_lambda > TO_GAP_MS);
      toe_armed_in = toe_armed_mid & ~to;
      ms_armed_mid = ms_armed_mid | to;

      ms = is_max && (last_rate_ff > ms_thr_ff) && ms_armed_mid;
      ms_time_in  = ms ? now_ff : ms_time_ff;
      ms_armed_in = ms_armed_mid & ~ms;

      // narrow band over the window, above the still floor, means standing still
      spread = 17'(wmax_ff) - 17'(wmin_ff);
      if (spread <= STILL_SPREAD && wmax_ff > STILL_FLOOR && wmin_ff > STILL_FLOOR) begin
         class_in = CLS_STATIONARY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_rate_ff    <= '0;
         older_rate_ff   <= '0;
         parity_ff       <= PAR_NONE;
         lambda_armed_ff <= 1'b0;
         ms_armed_ff     <= 1'b0;
         cross_armed_ff  <= 1'b0;
         toe_armed_ff    <= 1'b0;
         heel_rate_ff    <= '0;
         heel_time_ff    <= '0;
         ms_time_ff      <= '0;
         lambda_time_ff  <= '0;
         heel_gap_ff     <= '0;
         class_ff        <= CLS_UNKNOWN;
      end else if (cmd.commit) begin
         last_rate_ff    <= wz_ff;
         older_rate_ff   <= last_rate_ff;
         parity_ff       <= parity_in;
         lambda_armed_ff <= lambda_armed_in;
         ms_armed_ff     <= ms_armed_in;
         cross_armed_ff  <= cross_armed_in;
         toe_armed_ff    <= toe_armed_in;
         heel_rate_ff    <= heel_rate_in;
         heel_time_ff    <= heel_time_in;
         ms_time_ff      <= ms_time_in;
         lambda_time_ff  <= lambda_time_in;
         heel_gap_ff     <= heel_gap_in;
         class_ff        <= class_in;
      end
   end

   // result register
   logic       rsp_vld_ff;
   logic [4:0] flags_ff;
   logic [2:0] act_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         flags_ff   <= {hs, zc, lp, to, ms};
         act_out_ff <= class_in;
      end
   end

   assign stat.out_free     = !rsp_vld_ff || rsp.ready;
   assign rsp.valid         = rsp_vld_ff;
   assign rsp.heel_strike   = flags_ff[4];
   assign rsp.zero_crossing = flags_ff[3];
   assign rsp.lambda_peak   = flags_ff[2];
   assign rsp.toe_off       = flags_ff[1];
   assign rsp.midswing      = flags_ff[0];
   assign rsp.activity      = act_out_ff;

endmodule

// ===== design/ged_controller.sv =====
// ----------------------------------------------------------------------------
// Gait event detector controller
// Sequences sample capture, the window scan, evaluation and result hand-off.
// ----------------------------------------------------------------------------
module ged_controller
   import ged_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ged_stat_type stat,
   output ged_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
            if (stat.scan_last) state_in = ST_LAST;
         end
         // last read data lands in the min/max registers
         ST_LAST: begin
            state_in = ST_EVAL;
         end
         // hold until the result register frees up
         ST_EVAL: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== design/gait_event_detector.sv =====
// ----------------------------------------------------------------------------
// Gait event detector
// Flags gait events from gyro Z samples and classifies walking activity.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per sample: gyro_rate (signed, 1/16 dps) and
//   time_ms. rsp returns exactly one beat per sample with five event flags
//   and the activity class after that sample.
//   csr_wr_en/csr_index/csr_data write the four thresholds; write them only
//   while the block is idle.
// Sequence:
//   After a sample is accepted, its window is scanned entry by entry
//   through the single read port over the fill entries held (fill is up
//   to WINDOW_DEPTH), the last entry is folded into the min/max, and the
//   sample is evaluated; the result loads once the result register is free.
//   req_ready rises the cycle after the result loads, so a new sample is
//   taken only once the previous one has been evaluated and committed.
// Reset:
//   Synchronous, active high; clears the tracking state, the window fill
//   count and the result valid. Thresholds return to their defaults.
// Stall:
//   The result register holds while rsp_ready is low; the next sample is
//   still taken and waits in evaluation until the result register frees.
// ----------------------------------------------------------------------------
`include "gait_event_detector_assert.svh"

module gait_event_detector
   import ged_pkg::*;
#(
   parameter int WINDOW_DEPTH = 15
) (
   input  logic        clock,
   input  logic        reset,
   ged_req_if.sink     req,
   ged_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   ged_cmd_type  cmd;
   ged_stat_type stat;
   logic         ready;
   logic         hs_beat;

   assign req.ready = ready;
   assign hs_beat   = rsp.valid && rsp.heel_strike;

   ged_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ged_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .in_rate   (req.gyro_rate),
      .in_time   (req.time_ms),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp       (rsp)
   );

   // a taken beat keeps the block busy for at least the scan
   `GED_ASSERT_NEXT(a_busy_after_accept, clock, reset, req.valid && req.ready, !req.ready)
   // never overwrite a result that has not been taken
   `GED_ASSERT_SAME(a_commit_free, clock, reset, cmd.commit, stat.out_free)
   // a heel strike restarts the heel timer, so no zero crossing or lambda peak can join it
   `GED_ASSERT_SAME(a_heel_alone, clock, reset, hs_beat, !rsp.zero_crossing && !rsp.lambda_peak)

endmodule
